FILE: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// shared types and constants of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned ADDR_W    = 32;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

endpackage

FILE: rtl/page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// first-fit physical page allocator over a one-bit-per-page used map
//
//   channel  dir  tdata                                tuser
//   s_*      in   [31:0] page_addr                     [1:0] mode
//   m_*      out  [31:0] alloc_addr, [44:32] free_cnt  [0] ok
//   cfg_*    in   [12:0] total / reserved page count   -
//
// alloc: reads and checks the map words in turn until a hit or a miss;
// free: reads the page's word and clears its bit, skipped for a page past the total;
// init: writes every map word in turn; unused mode: goes to the result, ok low.
// the sequencer makes at most one map read or one map write a cycle.
// reset: map reads as all used through per-word valid bits, count zero.
// a result held on m_* stalls the sequencer only at its last step.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top
  import pba_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // page_addr
  input  logic [1:0]  s_tuser_i,   // mode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,   // alloc_addr, free_count, zero fill
  output logic        m_tuser_o,   // ok
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned MAX_REACH = (1 << CNT_W) / WORD_BITS;
  localparam int unsigned MEM_WORDS = (MAP_WORDS < MAX_REACH) ? MAP_WORDS : MAX_REACH;
  localparam int unsigned WIDX_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned WCNT_W    = WIDX_W + 1;
  localparam int unsigned PB_SH     = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W    = ADDR_W - PB_SH;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] PAGE_CAP =
    (MAX_PAGES > ((1 << CNT_W) - 1)) ? CNT_W'((1 << CNT_W) - 1) : CNT_W'(MAX_PAGES);
  localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(MEM_WORDS - 1);
  localparam logic [WCNT_W-1:0] END_WORD  = WCNT_W'(MEM_WORDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_e;

  function automatic logic [WORD_BITS-1:0] page_bits(logic [WCNT_W-1:0] w,
                                                     logic [CNT_W-1:0] lim);
    logic [CNT_W:0] base;
    logic [CNT_W:0] rem;
    begin
      base = (CNT_W+1)'(w) << BIT_W;
      rem  = {1'b0, lim} - base;
      if ({1'b0, lim} <= base) begin
        page_bits = '0;
      end else if (rem >= (CNT_W+1)'(WORD_BITS)) begin
        page_bits = '1;
      end else begin
        page_bits = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
      end
    end
  endfunction

  // configuration
  logic [CNT_W-1:0] total_q, reserved_q;
  logic [CNT_W-1:0] eff_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_RESET;
      reserved_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:    total_q    <= cfg_data_i;
        CFG_RESERVED: reserved_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign eff_total = (total_q > PAGE_CAP) ? PAGE_CAP : total_q;

  // used map
  logic [WORD_BITS-1:0] mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] wvalid_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic                 mem_we, mem_re;
  logic [WIDX_W-1:0]    mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WORD_BITS-1:0] word_rd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        wvalid_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= wvalid_q[mem_ra];
      end
    end
  end

  assign word_rd = rd_vld_q ? rd_data_q : '1;

  // sequencer
  state_e            state_q, state_d;
  logic [WCNT_W-1:0] wcnt_q, wcnt_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic              res_ok_q, res_ok_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              out_vld_q, out_vld_d;
  logic              out_ok_q, out_ok_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic [PAGE_W-1:0]    in_page;
  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     first_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [CNT_W-1:0]     init_cnt;
  logic [ADDR_W-1:0]    found_page;

  assign in_page  = s_tdata_i[ADDR_W-1:PB_SH];
  assign avail    = ~word_rd & page_bits(wcnt_q, eff_total);
  assign bit_mask = WORD_BITS'(1) << bit_q;
  assign init_cnt = (eff_total > reserved_q) ? (eff_total - reserved_q) : '0;

  always_comb begin
    first_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        first_bit = BIT_W'(i);
      end
    end
  end

  assign found_page = ((ADDR_W'(wcnt_q) << BIT_W) | ADDR_W'(first_bit)) << PB_SH;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    bit_d      = bit_q;
    free_d     = free_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    out_vld_d  = out_vld_q && !m_tready_i;
    out_ok_d   = out_ok_q;
    out_addr_d = out_addr_q;
    out_cnt_d  = out_cnt_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = wcnt_q[WIDX_W-1:0];
    mem_ra     = wcnt_q[WIDX_W-1:0];
    mem_wd     = '1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          res_ok_d   = 1'b1;
          res_addr_d = '0;
          wcnt_d     = '0;
          unique case (mode_e'(s_tuser_i))
            MODE_ALLOC: begin
              res_ok_d = 1'b0;
              state_d  = ST_SCAN_RD;
            end
            MODE_FREE: begin
              if (in_page < PAGE_W'(eff_total)) begin
                wcnt_d  = WCNT_W'(in_page[WIDX_W+BIT_W-1:BIT_W]);
                bit_d   = in_page[BIT_W-1:0];
                state_d = ST_FREE_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            MODE_INIT: begin
              state_d = ST_INIT;
            end
            MODE_NONE: begin
              res_ok_d = 1'b0;
              state_d  = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = ~(page_bits(wcnt_q, eff_total) & ~page_bits(wcnt_q, reserved_q));
        wcnt_d = wcnt_q + WCNT_W'(1);
        if (wcnt_q == LAST_WORD) begin
          free_d  = init_cnt;
          state_d = ST_DONE;
        end
      end

      ST_SCAN_RD: begin
        if (wcnt_q == END_WORD || page_bits(wcnt_q, eff_total) == '0) begin
          state_d = ST_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (avail != '0) begin
          mem_we     = 1'b1;
          mem_wd     = word_rd | (WORD_BITS'(1) << first_bit);
          res_ok_d   = 1'b1;
          res_addr_d = found_page;
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
          state_d = ST_DONE;
        end else begin
          wcnt_d  = wcnt_q + WCNT_W'(1);
          state_d = ST_SCAN_RD;
        end
      end

      ST_FREE_RD: begin
        mem_re  = 1'b1;
        state_d = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        if ((word_rd & bit_mask) != '0) begin
          mem_we = 1'b1;
          mem_wd = word_rd & ~bit_mask;
          free_d = free_q + CNT_W'(1);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || m_tready_i) begin
          out_vld_d  = 1'b1;
          out_ok_d   = res_ok_q;
          out_addr_d = res_addr_q;
          out_cnt_d  = free_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wcnt_q     <= '0;
      bit_q      <= '0;
      free_q     <= '0;
      res_ok_q   <= 1'b0;
      res_addr_q <= '0;
      out_vld_q  <= 1'b0;
      out_ok_q   <= 1'b0;
      out_addr_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      wcnt_q     <= wcnt_d;
      bit_q      <= bit_d;
      free_q     <= free_d;
      res_ok_q   <= res_ok_d;
      res_addr_q <= res_addr_d;
      out_vld_q  <= out_vld_d;
      out_ok_q   <= out_ok_d;
      out_addr_q <= out_addr_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_ok_q;
  assign m_tdata_o  = {3'b000, out_cnt_q, out_addr_q};

endmodule

FILE: bench/tb_page_bitmap_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator_top
// self-checking bench for the first-fit page bitmap allocator
//
// a behavioural copy of the used map, the free count and both page-count
// registers predicts ok, alloc_addr and free_count for every accepted
// transaction; each result leaving m_* is compared with the oldest prediction.
// directed tests cover the post-reset map, every mode, saturation of the page
// count, reserved pages at and past the total, double frees, frees past the
// total and register changes without a rebuild. these are followed by a
// back-pressure test, a gap-free stream and randomised phases over many
// register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_top;
  import pba_pkg::*;

  localparam int unsigned MAX_PAGES   = 4096;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned MAP_WORDS   = MAX_PAGES / WORD_BITS;
  localparam int unsigned OP_LATENCY  = 2 * MAP_WORDS + 4;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } page_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [31:0] s_tdata_i;
  logic [1:0]  s_tuser_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [47:0] m_tdata_o;
  logic        m_tuser_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [12:0] cfg_data_i;

  logic [WORD_BITS-1:0] model_map [MAP_WORDS];
  logic [CNT_W-1:0]     model_free;
  logic [CNT_W-1:0]     model_total;
  logic [CNT_W-1:0]     model_reserved;
  page_result_t         page_results_q [$];

  int unsigned mismatch_count;
  int unsigned result_idx;
  int unsigned hold_left;
  bit          steady;

  page_bitmap_allocator_top #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic page_result_t predict_page_op(input mode_e op, input logic [31:0] addr);
    page_result_t r;
    int unsigned  limit;
    int unsigned  pg;
    r = '0;
    limit = (model_total > MAX_PAGES) ? MAX_PAGES : model_total;
    case (op)
      MODE_ALLOC: begin
        for (int unsigned p = 0; p < limit && !r.ok; p++) begin
          if (!model_map[p / WORD_BITS][p % WORD_BITS]) begin
            model_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
            if (model_free != 0) model_free = model_free - 1'b1;
            r.ok   = 1'b1;
            r.addr = p * PAGE_BYTES;
          end
        end
      end
      MODE_FREE: begin
        r.ok = 1'b1;
        pg = addr / PAGE_BYTES;
        if (pg < limit && model_map[pg / WORD_BITS][pg % WORD_BITS]) begin
          model_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
          model_free = model_free + 1'b1;
        end
      end
      MODE_INIT: begin
        foreach (model_map[w]) model_map[w] = '1;
        model_free = '0;
        for (int unsigned p = model_reserved; p < limit; p++) begin
          model_map[p / WORD_BITS][p % WORD_BITS] = 1'b0;
          model_free = model_free + 1'b1;
        end
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = model_free;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch %0d: %s", mismatch_count, msg);
  endtask

  // result sink: random stalls, long holds on request, none while steady
  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else if (steady) begin
        m_tready_i <= 1'b1;
      end else begin
        m_tready_i <= ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (page_results_q.size() == 0) begin
        note_mismatch($sformatf("result %0d with no transaction outstanding", result_idx));
      end else begin
        want = page_results_q.pop_front();
        if (m_tuser_o !== want.ok)
          note_mismatch($sformatf("result %0d ok got %0b want %0b",
                                  result_idx, m_tuser_o, want.ok));
        if (m_tdata_o[31:0] !== want.addr)
          note_mismatch($sformatf("result %0d alloc_addr got %h want %h",
                                  result_idx, m_tdata_o[31:0], want.addr));
        if (m_tdata_o[44:32] !== want.count)
          note_mismatch($sformatf("result %0d free_count got %0d want %0d",
                                  result_idx, m_tdata_o[44:32], want.count));
        if (m_tdata_o[47:45] !== 3'b000)
          note_mismatch($sformatf("result %0d fill bits got %b", result_idx, m_tdata_o[47:45]));
      end
      result_idx++;
    end
  end

  task automatic send_op(input mode_e op, input logic [31:0] addr);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        s_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= addr;
    page_results_q.push_back(predict_page_op(op, addr));
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (page_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_TOTAL) model_total = val;
    else model_reserved = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_op();
    int unsigned limit;
    int unsigned near;
    int unsigned roll;
    int unsigned sel;
    mode_e       op;
    logic [31:0] addr;
    limit = (model_total > MAX_PAGES) ? MAX_PAGES : model_total;
    near  = ((limit < 64) ? limit : 64) + 3;
    roll  = $urandom_range(99);
    addr  = $urandom();
    if (roll < 48) begin
      op = MODE_ALLOC;
    end else if (roll < 92) begin
      op  = MODE_FREE;
      sel = $urandom_range(99);
      if (sel < 60) addr = $urandom_range(near) * PAGE_BYTES + addr % PAGE_BYTES;
      else if (sel < 85) addr = $urandom_range(limit) * PAGE_BYTES + addr % PAGE_BYTES;
    end else if (roll < 96) begin
      op = MODE_INIT;
    end else begin
      op = MODE_NONE;
    end
    send_op(op, addr);
  endtask

  // map after reset: everything used, count zero, reset page count
  task automatic test_reset_map();
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_FREE, 32'h0000_5123);
    send_op(MODE_ALLOC, 32'hFFFF_FFFF);
    send_op(MODE_NONE, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_op(MODE_INIT, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_FREE, 32'h0000_0FFF);
    send_op(MODE_FREE, 32'h0000_0000);
    send_op(MODE_FREE, 32'hFFFF_FFFF);
    send_op(MODE_FREE, 32'h00FF_F000);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(CFG_TOTAL, 13'd0);
    write_reg(CFG_RESERVED, 13'd0);
    send_op(MODE_INIT, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    wait_idle();
    write_reg(CFG_TOTAL, 13'd8191);
    write_reg(CFG_RESERVED, 13'd4095);
    send_op(MODE_INIT, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    wait_idle();
    write_reg(CFG_RESERVED, 13'd8191);
    send_op(MODE_INIT, 32'h0000_0000);
    wait_idle();
    write_reg(CFG_TOTAL, 13'd33);
    write_reg(CFG_RESERVED, 13'd31);
    send_op(MODE_INIT, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_FREE, 32 * PAGE_BYTES + 32'h7);
    // shrink the total with no rebuild: page 32 stays clear but out of reach
    wait_idle();
    write_reg(CFG_TOTAL, 13'd16);
    send_op(MODE_ALLOC, 32'h0000_0000);
    send_op(MODE_FREE, 20 * PAGE_BYTES);
    send_op(MODE_FREE, 3 * PAGE_BYTES + 32'hABC);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(CFG_TOTAL, 13'd96);
    write_reg(CFG_RESERVED, 13'd0);
    send_op(MODE_INIT, 32'h0000_0000);
    wait_idle();
    hold_left = 300;
    repeat (40) send_random_op();
    wait_idle();
  endtask

  task automatic test_streaming();
    wait_idle();
    write_reg(CFG_TOTAL, 13'd256);
    write_reg(CFG_RESERVED, 13'd40);
    steady = 1'b1;
    send_op(MODE_INIT, 32'h0000_0000);
    repeat (120) send_random_op();
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [12:0] tot;
    logic [12:0] res;
    int unsigned roll;
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      case ($urandom_range(5))
        0: tot = 13'($urandom_range(8191));
        1: begin
          case ($urandom_range(3))
            0: tot = 13'd0;
            1: tot = 13'd1;
            2: tot = 13'd4096;
            default: tot = 13'd8191;
          endcase
        end
        2: tot = 13'($urandom_range(33, 31));
        default: tot = 13'($urandom_range(160, 2));
      endcase
      roll = $urandom_range(99);
      if (roll < 15) res = 13'd0;
      else if (roll < 30) res = 13'($urandom_range(8191));
      else res = 13'($urandom_range((tot < 160) ? tot : 160));
      write_reg(CFG_TOTAL, tot);
      write_reg(CFG_RESERVED, res);
      send_op(MODE_INIT, $urandom());
      repeat (55) send_random_op();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    s_tuser_i      = MODE_NONE;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_TOTAL;
    cfg_data_i     = '0;
    steady         = 1'b0;
    hold_left      = 0;
    mismatch_count = 0;
    result_idx     = 0;
    foreach (model_map[w]) model_map[w] = '1;
    model_free     = '0;
    model_total    = TOTAL_RESET;
    model_reserved = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_map();
    test_basic_ops();
    test_config_extremes();
    test_backpressure();
    test_streaming();
    test_random_phases();
    wait_idle();
    repeat (OP_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && page_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pba_pkg.sv
rtl/page_bitmap_allocator_top.sv
bench/tb_page_bitmap_allocator_top.sv
